// ===== rtl/init_handshake_line_checker_defines.svh =====
// Assertion macros for the INIT handshake line checker.
`ifndef INIT_HANDSHAKE_LINE_CHECKER_DEFINES_SVH
`define INIT_HANDSHAKE_LINE_CHECKER_DEFINES_SVH

// Same-cycle implication, idle while reset is asserted.
`define IHLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line checker: same-cycle property failed");

// Next-cycle implication, idle while reset is asserted.
`define IHLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line checker: next-cycle property failed");

// Next-cycle implication, checked through reset.
`define IHLC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("line checker: reset property failed");

`endif

// ===== rtl/ihlc_pkg.sv =====
package ihlc_pkg;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_NOT_INIT       = 3'd1,
        ST_MALFORMED      = 3'd2,
        ST_COUNT_RANGE    = 3'd3,
        ST_ID_RANGE       = 3'd4,
        ST_ID_MISMATCH    = 3'd5,
        ST_COUNT_MISMATCH = 3'd6,
        ST_CRC_BAD        = 3'd7
    } t_status;

    typedef enum logic {
        CFG_OWN_ID      = 1'b0,
        CFG_ROBOT_COUNT = 1'b1
    } t_cfg_idx;

    localparam int CFG_WIDTH = 4;

    localparam logic [1:0] FIELD_ID    = 2'd0;
    localparam logic [1:0] FIELD_COUNT = 2'd1;
    localparam logic [1:0] FIELD_CHECK = 2'd2;

    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [2:0] CRC_SETTLE = 3'd4;

    localparam logic [3:0] COUNT_MIN = 4'd2;
    localparam logic [3:0] COUNT_MAX = 4'd4;
    localparam logic [3:0] TEN       = 4'd10;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_VT      = 8'd11;
    localparam logic [7:0] CH_FF      = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_T       = 8'h54;

    function automatic logic [7:0] prefix_char(logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CH_I;
            3'd1:    c = CH_N;
            3'd2:    c = CH_I;
            3'd3:    c = CH_T;
            3'd4:    c = CH_COLON;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/ihlc_rx_if.sv =====
interface ihlc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ihlc_verdict_if.sv =====
interface ihlc_verdict_if;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [3:0]        reported_id;
    ihlc_pkg::t_status status;

    modport source (output valid, output accepted, output reported_id, output status,
                    input ready);
    modport sink (input valid, input accepted, input reported_id, input status,
                  output ready);
endinterface

// ===== rtl/init_handshake_line_checker.sv =====
// INIT handshake line checker: takes one received byte per beat on i_rx and, for each
// newline, gives one verdict beat on o_verdict (accepted, reported_id, status) for the line
// "INIT:id,count,crc"; other bytes give no beat. A byte is taken every clock unless the
// checker stalls (check byte settling, or a newline held by a stalled verdict): it enters an
// input register, and once consumed the per-byte parse updates the line state or, on a
// newline, loads the verdict into the output register. After each configuration write the
// expected check byte is rebuilt through four chained one-byte CRC registers, and bytes
// hold in the input register while it settles; the same applies after reset.
module init_handshake_line_checker #(
    parameter int VALUE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ihlc_rx_if.sink                           i_rx,
    ihlc_verdict_if.source                    o_verdict,
    input  logic                              i_cfg_we,
    input  ihlc_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [ihlc_pkg::CFG_WIDTH-1:0]    i_cfg_data
);
    import ihlc_pkg::*;

    localparam logic [VALUE_BITS-1:0] VALUE_TOP = {VALUE_BITS{1'b1}};

    logic [3:0]            r_own_id;
    logic [3:0]            r_robot_count;
    logic [2:0]            r_settle;
    logic [7:0]            r_crc_a;
    logic [7:0]            r_crc_b;
    logic [7:0]            r_crc_c;
    logic [7:0]            r_crc_d;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;

    logic [2:0]            r_prefix_pos,    n_prefix_pos;
    logic                  r_prefix_failed, n_prefix_failed;
    logic [1:0]            r_field_number,  n_field_number;
    logic                  r_field_neg,     n_field_neg;
    logic                  r_field_signed,  n_field_signed;
    logic                  r_field_has_dig, n_field_has_dig;
    logic                  r_field_done,    n_field_done;
    logic [VALUE_BITS-1:0] r_id_value,      n_id_value;
    logic [VALUE_BITS-1:0] r_count_value,   n_count_value;
    logic [VALUE_BITS-1:0] r_check_value,   n_check_value;
    logic                  r_id_neg,        n_id_neg;
    logic                  r_count_neg,     n_count_neg;
    logic                  r_malformed,     n_malformed;

    logic                  r_out_valid;
    logic                  r_out_accepted;
    logic [3:0]            r_out_id;
    t_status               r_out_status;

    logic                  is_nl;
    logic                  is_digit;
    logic                  is_blank;
    logic                  is_sign;
    logic                  consume;
    logic [7:0]            digit_diff;
    logic [VALUE_BITS-1:0] cur_value;
    logic [VALUE_BITS+3:0] acc_wide;
    logic [VALUE_BITS-1:0] acc_value;
    logic [3:0]            own_ones;
    t_status               v_status;

    assign is_nl    = (r_in_byte == CH_NEWLINE);
    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign is_blank = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB) ||
                      (r_in_byte == CH_VT) || (r_in_byte == CH_FF) || (r_in_byte == CH_CR);
    assign is_sign  = (r_in_byte == CH_PLUS) || (r_in_byte == CH_MINUS);

    assign consume = r_in_valid && (r_settle == 3'd0) &&
                     (!is_nl || !r_out_valid || o_verdict.ready);

    assign i_rx.ready = !r_in_valid || consume;

    assign digit_diff = r_in_byte - CH_ZERO;
    assign cur_value  = (r_field_number == FIELD_ID)    ? r_id_value :
                        (r_field_number == FIELD_COUNT) ? r_count_value : r_check_value;
    assign acc_wide   = {1'b0, cur_value, 3'b000} + {3'b000, cur_value, 1'b0} +
                        {{VALUE_BITS{1'b0}}, digit_diff[3:0]};
    assign acc_value  = (acc_wide > {4'b0000, VALUE_TOP}) ? VALUE_TOP
                                                          : acc_wide[VALUE_BITS-1:0];

    assign own_ones = (r_own_id >= TEN) ? (r_own_id - TEN) : r_own_id;

    always_comb begin
        if (r_prefix_failed || (r_prefix_pos < PREFIX_LEN)) begin
            v_status = ST_NOT_INIT;
        end else if (r_malformed || (r_field_number != FIELD_CHECK) || !r_field_has_dig) begin
            v_status = ST_MALFORMED;
        end else if (r_count_neg || (r_count_value < VALUE_BITS'(COUNT_MIN)) ||
                     (r_count_value > VALUE_BITS'(COUNT_MAX))) begin
            v_status = ST_COUNT_RANGE;
        end else if ((r_id_neg && (r_id_value != '0)) ||
                     (r_id_value >= VALUE_BITS'(r_robot_count))) begin
            v_status = ST_ID_RANGE;
        end else if (r_id_value != VALUE_BITS'(r_own_id)) begin
            v_status = ST_ID_MISMATCH;
        end else if (r_count_value != VALUE_BITS'(r_robot_count)) begin
            v_status = ST_COUNT_MISMATCH;
        end else if ((r_check_value != VALUE_BITS'(r_crc_d)) ||
                     (r_field_neg && (r_check_value != '0))) begin
            v_status = ST_CRC_BAD;
        end else begin
            v_status = ST_OK;
        end
    end

    always_comb begin
        n_prefix_pos    = r_prefix_pos;
        n_prefix_failed = r_prefix_failed;
        n_field_number  = r_field_number;
        n_field_neg     = r_field_neg;
        n_field_signed  = r_field_signed;
        n_field_has_dig = r_field_has_dig;
        n_field_done    = r_field_done;
        n_id_value      = r_id_value;
        n_count_value   = r_count_value;
        n_check_value   = r_check_value;
        n_id_neg        = r_id_neg;
        n_count_neg     = r_count_neg;
        n_malformed     = r_malformed;
        if (consume) begin
            if (is_nl) begin
                n_prefix_pos    = '0;
                n_prefix_failed = 1'b0;
                n_field_number  = FIELD_ID;
                n_field_neg     = 1'b0;
                n_field_signed  = 1'b0;
                n_field_has_dig = 1'b0;
                n_field_done    = 1'b0;
                n_id_value      = '0;
                n_count_value   = '0;
                n_check_value   = '0;
                n_id_neg        = 1'b0;
                n_count_neg     = 1'b0;
                n_malformed     = 1'b0;
            end else if (!r_prefix_failed && (r_prefix_pos < PREFIX_LEN)) begin
                if (r_in_byte == prefix_char(r_prefix_pos)) begin
                    n_prefix_pos = r_prefix_pos + 3'd1;
                end else begin
                    n_prefix_failed = 1'b1;
                end
            end else if (!r_prefix_failed && !r_malformed && !r_field_done) begin
                if (is_digit) begin
                    n_field_has_dig = 1'b1;
                    if (r_field_number == FIELD_ID) begin
                        n_id_value = acc_value;
                    end else if (r_field_number == FIELD_COUNT) begin
                        n_count_value = acc_value;
                    end else begin
                        n_check_value = acc_value;
                    end
                end else if (r_field_has_dig) begin
                    if (r_field_number >= FIELD_CHECK) begin
                        n_field_done = 1'b1;
                    end else if (r_in_byte == CH_COMMA) begin
                        if (r_field_number == FIELD_ID) begin
                            n_id_neg = r_field_neg;
                        end else begin
                            n_count_neg = r_field_neg;
                        end
                        n_field_number  = r_field_number + 2'd1;
                        n_field_neg     = 1'b0;
                        n_field_signed  = 1'b0;
                        n_field_has_dig = 1'b0;
                    end else begin
                        n_malformed = 1'b1;
                    end
                end else if (!r_field_signed && is_sign) begin
                    n_field_signed = 1'b1;
                    n_field_neg    = (r_in_byte == CH_MINUS);
                end else if (r_field_signed || !is_blank) begin
                    n_malformed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id        <= '0;
            r_robot_count   <= 4'd3;
            r_settle        <= CRC_SETTLE;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_prefix_pos    <= '0;
            r_prefix_failed <= 1'b0;
            r_field_number  <= FIELD_ID;
            r_field_neg     <= 1'b0;
            r_field_signed  <= 1'b0;
            r_field_has_dig <= 1'b0;
            r_field_done    <= 1'b0;
            r_id_value      <= '0;
            r_count_value   <= '0;
            r_check_value   <= '0;
            r_id_neg        <= 1'b0;
            r_count_neg     <= 1'b0;
            r_malformed     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OWN_ID:      r_own_id      <= i_cfg_data;
                    CFG_ROBOT_COUNT: r_robot_count <= i_cfg_data;
                endcase
                r_settle <= CRC_SETTLE;
            end else if (r_settle != 3'd0) begin
                r_settle <= r_settle - 3'd1;
            end

            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end

            if (consume && is_nl) begin
                r_out_valid <= 1'b1;
            end else if (o_verdict.ready) begin
                r_out_valid <= 1'b0;
            end

            r_prefix_pos    <= n_prefix_pos;
            r_prefix_failed <= n_prefix_failed;
            r_field_number  <= n_field_number;
            r_field_neg     <= n_field_neg;
            r_field_signed  <= n_field_signed;
            r_field_has_dig <= n_field_has_dig;
            r_field_done    <= n_field_done;
            r_id_value      <= n_id_value;
            r_count_value   <= n_count_value;
            r_check_value   <= n_check_value;
            r_id_neg        <= n_id_neg;
            r_count_neg     <= n_count_neg;
            r_malformed     <= n_malformed;
        end
    end

    // rebuild the expected check byte over the text "id,count", one character per stage
    always_ff @(posedge i_clk) begin
        r_crc_a <= (r_own_id >= TEN) ? crc_byte(8'h00, CH_ONE) : 8'h00;
        r_crc_b <= crc_byte(r_crc_a, CH_ZERO + {4'b0000, own_ones});
        r_crc_c <= crc_byte(r_crc_b, CH_COMMA);
        r_crc_d <= crc_byte(r_crc_c, CH_ZERO + {4'b0000, r_robot_count});

        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end

        if (consume && is_nl) begin
            r_out_accepted <= (v_status == ST_OK);
            r_out_id       <= (v_status == ST_OK) ? r_id_value[3:0] : 4'd0;
            r_out_status   <= v_status;
        end
    end

    assign o_verdict.valid       = r_out_valid;
    assign o_verdict.accepted    = r_out_accepted;
    assign o_verdict.reported_id = r_out_id;
    assign o_verdict.status      = r_out_status;

endmodule

// ===== rtl/ihlc_checker.sv =====
`include "init_handshake_line_checker_defines.svh"

module ihlc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rx_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_accepted,
    input logic [3:0]        i_reported_id,
    input ihlc_pkg::t_status i_status
);
    import ihlc_pkg::*;

    `IHLC_ASSERT_SAME(a_accept_matches_status, i_clk, i_rst_n, i_out_valid, (i_accepted == (i_status == ST_OK)))
    `IHLC_ASSERT_SAME(a_rejected_id_zero, i_clk, i_rst_n, (i_out_valid && !i_accepted), (i_reported_id == 4'd0))
    `IHLC_ASSERT_NEXT(a_stalled_beat_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready), (i_out_valid && $stable(i_accepted) && $stable(i_status) && $stable(i_reported_id)))
    `IHLC_ASSERT_NEXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, (!i_out_valid && i_rx_ready))

endmodule

bind init_handshake_line_checker ihlc_checker u_ihlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_ready    (i_rx.ready),
    .i_out_valid   (o_verdict.valid),
    .i_out_ready   (o_verdict.ready),
    .i_accepted    (o_verdict.accepted),
    .i_reported_id (o_verdict.reported_id),
    .i_status      (o_verdict.status)
);
